FILE: sv/atti_pkg.sv
// Shared constants, table and types for the table-interpolated atan2 core.
`default_nettype none

package atti_pkg;

    localparam int COORD_WIDTH         = 16;
    localparam int MAG_WIDTH           = COORD_WIDTH;
    localparam int ANGLE_WIDTH         = 16;
    localparam int FRAC_BITS           = 16;
    localparam int Q_WIDTH             = FRAC_BITS + 1;
    localparam int TABLE_SEGMENTS      = 16;
    localparam int TABLE_INTERVALS     = TABLE_SEGMENTS - 1;
    localparam int IDX_WIDTH           = $clog2(TABLE_SEGMENTS);
    localparam int P_WIDTH             = Q_WIDTH + IDX_WIDTH;
    localparam int TAB_WIDTH           = 14;
    localparam int DIFF_WIDTH          = 10;
    localparam int PROD_WIDTH          = FRAC_BITS + DIFF_WIDTH;
    localparam int DIV_STEPS           = Q_WIDTH;
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          =
        (DIV_STEPS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

    localparam logic [MAG_WIDTH-1:0]   MAG_ONE     = MAG_WIDTH'(1);
    localparam logic [IDX_WIDTH-1:0]   IDX_ONE     = IDX_WIDTH'(1);
    localparam logic [IDX_WIDTH-1:0]   LAST_IDX    = IDX_WIDTH'(TABLE_INTERVALS);
    localparam logic [P_WIDTH-1:0]     INTERVALS_P = P_WIDTH'(TABLE_INTERVALS);
    localparam logic [P_WIDTH-1:0]     MAX_P       =
        P_WIDTH'(TABLE_INTERVALS) << FRAC_BITS;
    localparam logic [PROD_WIDTH:0]    ROUND_HALF  =
        (PROD_WIDTH + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [ANGLE_WIDTH-1:0] EIGHTH_TURN  = 16'h2000;
    localparam logic [ANGLE_WIDTH-1:0] QUARTER_TURN = 16'h4000;
    localparam logic [ANGLE_WIDTH-1:0] HALF_TURN    = 16'h8000;

    // Arctangent of k/15 in units of 1/65536 turn, rounded to nearest.
    localparam logic [TAB_WIDTH-1:0] ATAN_TABLE [TABLE_SEGMENTS] = '{
        14'd0,    14'd694,  14'd1383, 14'd2059,
        14'd2718, 14'd3356, 14'd3969, 14'd4554,
        14'd5110, 14'd5637, 14'd6133, 14'd6600,
        14'd7038, 14'd7448, 14'd7832, 14'd8192
    };

    typedef struct packed {
        logic y_neg;
        logic x_neg;
        logic y_big;
        logic zero;
    } side_t;

endpackage

`default_nettype wire

FILE: sv/atti_div.sv
// Pipelined restoring divider forming the Q1.16 ratio of the smaller to the larger magnitude.
`default_nettype none

module atti_div (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             advance,
    input  wire logic                             in_valid,
    input  wire logic [atti_pkg::MAG_WIDTH-1:0]   in_small,
    input  wire logic [atti_pkg::MAG_WIDTH-1:0]   in_big,
    input  wire atti_pkg::side_t                  in_side,
    output logic                                  out_valid,
    output logic [atti_pkg::Q_WIDTH-1:0]          out_quot,
    output atti_pkg::side_t                       out_side
);

    logic                             valid_reg [atti_pkg::DIV_STAGES];
    logic [atti_pkg::MAG_WIDTH-1:0]   rem_reg   [atti_pkg::DIV_STAGES];
    logic [atti_pkg::MAG_WIDTH-1:0]   big_reg   [atti_pkg::DIV_STAGES];
    logic [atti_pkg::Q_WIDTH-1:0]     quot_reg  [atti_pkg::DIV_STAGES];
    logic [atti_pkg::Q_WIDTH-1:0]     dvd_reg   [atti_pkg::DIV_STAGES];
    atti_pkg::side_t                  side_reg  [atti_pkg::DIV_STAGES];

    logic [atti_pkg::MAG_WIDTH-1:0]   rem_next  [atti_pkg::DIV_STAGES];
    logic [atti_pkg::MAG_WIDTH-1:0]   big_next  [atti_pkg::DIV_STAGES];
    logic [atti_pkg::Q_WIDTH-1:0]     quot_next [atti_pkg::DIV_STAGES];
    logic [atti_pkg::Q_WIDTH-1:0]     dvd_next  [atti_pkg::DIV_STAGES];
    atti_pkg::side_t                  side_next [atti_pkg::DIV_STAGES];

    genvar s;
    generate
        for (s = 0; s < atti_pkg::DIV_STAGES; s++) begin : g_stage
            logic [atti_pkg::MAG_WIDTH-1:0] rem_src;
            logic [atti_pkg::MAG_WIDTH-1:0] big_src;
            logic [atti_pkg::Q_WIDTH-1:0]   quot_src;
            logic [atti_pkg::Q_WIDTH-1:0]   dvd_src;
            atti_pkg::side_t                side_src;

            if (s == 0) begin : g_first
                // The low bit of the dividend is shifted in by the first step.
                assign rem_src  = in_small >> 1;
                assign big_src  = in_big;
                assign quot_src = '0;
                assign dvd_src  = {in_small[0], {(atti_pkg::Q_WIDTH-1){1'b0}}};
                assign side_src = in_side;
            end else begin : g_rest
                assign rem_src  = rem_reg[s-1];
                assign big_src  = big_reg[s-1];
                assign quot_src = quot_reg[s-1];
                assign dvd_src  = dvd_reg[s-1];
                assign side_src = side_reg[s-1];
            end

            always_comb begin
                logic [atti_pkg::MAG_WIDTH:0]   trial;
                logic [atti_pkg::MAG_WIDTH:0]   diff;
                logic [atti_pkg::MAG_WIDTH-1:0] rem;
                logic [atti_pkg::Q_WIDTH-1:0]   quot;
                logic [atti_pkg::Q_WIDTH-1:0]   dvd;
                trial = '0;
                diff  = '0;
                rem   = rem_src;
                quot  = quot_src;
                dvd   = dvd_src;
                for (int j = 0; j < atti_pkg::DIV_STEPS_PER_STAGE; j++) begin
                    if (s * atti_pkg::DIV_STEPS_PER_STAGE + j < atti_pkg::DIV_STEPS) begin
                        trial = {rem, dvd[atti_pkg::Q_WIDTH-1]};
                        dvd   = {dvd[atti_pkg::Q_WIDTH-2:0], 1'b0};
                        diff  = trial - {1'b0, big_src};
                        if (trial >= {1'b0, big_src}) begin
                            rem  = diff[atti_pkg::MAG_WIDTH-1:0];
                            quot = {quot[atti_pkg::Q_WIDTH-2:0], 1'b1};
                        end else begin
                            rem  = trial[atti_pkg::MAG_WIDTH-1:0];
                            quot = {quot[atti_pkg::Q_WIDTH-2:0], 1'b0};
                        end
                    end
                end
                rem_next[s]  = rem;
                quot_next[s] = quot;
                dvd_next[s]  = dvd;
                big_next[s]  = big_src;
                side_next[s] = side_src;
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < atti_pkg::DIV_STAGES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (advance) begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < atti_pkg::DIV_STAGES; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < atti_pkg::DIV_STAGES; i++) begin
                rem_reg[i]  <= rem_next[i];
                big_reg[i]  <= big_next[i];
                quot_reg[i] <= quot_next[i];
                dvd_reg[i]  <= dvd_next[i];
                side_reg[i] <= side_next[i];
            end
        end
    end

    assign out_valid = valid_reg[atti_pkg::DIV_STAGES-1];
    assign out_quot  = quot_reg[atti_pkg::DIV_STAGES-1];
    assign out_side  = side_reg[atti_pkg::DIV_STAGES-1];

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !out_valid)
        else $error("divider output valid after reset");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_side.zero
            |-> rem_reg[atti_pkg::DIV_STAGES-1] < big_reg[atti_pkg::DIV_STAGES-1])
        else $error("divider remainder not below divisor");

    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_side.zero
            |-> out_quot <= (atti_pkg::Q_WIDTH'(1) << atti_pkg::FRAC_BITS))
        else $error("ratio above one");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(out_valid) && $stable(out_quot))
        else $error("divider moved while stalled");

endmodule

`default_nettype wire

FILE: sv/atan2_turns_table_interp_core.sv
// Top level of the pipelined atan2 core returning the angle in fractions of a turn.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid, s_ready   s_y_coord, s_x_coord (16-bit signed)
//  m_        out        m_valid, m_ready   m_angle_turns (16-bit unsigned)
//
// One transfer is accepted per cycle while the output is not stalled. The depth
// is set by the nine stages of the ratio divider (two quotient bits each, one in
// the last) plus six stages for magnitude, ordering, index, table, multiply and
// fold. Reset is synchronous and clears only the valid bits. While m_valid is
// high and m_ready low, the whole pipeline holds and s_ready is low.
`default_nettype none

module atan2_turns_table_interp_core (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire logic                                       s_valid,
    output logic                                            s_ready,
    input  wire logic signed [atti_pkg::COORD_WIDTH-1:0]    s_y_coord,
    input  wire logic signed [atti_pkg::COORD_WIDTH-1:0]    s_x_coord,
    output logic                                            m_valid,
    input  wire logic                                       m_ready,
    output logic [atti_pkg::ANGLE_WIDTH-1:0]                m_angle_turns
);

    localparam logic [1:0] QUAD_FIRST  = 2'b00;
    localparam logic [1:0] QUAD_SECOND = 2'b10;
    localparam logic [1:0] QUAD_THIRD  = 2'b11;
    localparam logic [1:0] QUAD_FOURTH = 2'b01;

    logic adv;

    logic [atti_pkg::COORD_WIDTH-1:0] y_bits;
    logic [atti_pkg::COORD_WIDTH-1:0] x_bits;
    logic [atti_pkg::MAG_WIDTH-1:0]   ay_next;
    logic [atti_pkg::MAG_WIDTH-1:0]   ax_next;

    logic                             mag_valid_reg;
    logic [atti_pkg::MAG_WIDTH-1:0]   mag_ay_reg;
    logic [atti_pkg::MAG_WIDTH-1:0]   mag_ax_reg;
    logic                             mag_yneg_reg;
    logic                             mag_xneg_reg;

    logic                             srt_valid_reg;
    logic [atti_pkg::MAG_WIDTH-1:0]   srt_small_reg;
    logic [atti_pkg::MAG_WIDTH-1:0]   srt_big_reg;
    atti_pkg::side_t                  srt_side_reg;
    atti_pkg::side_t                  srt_side_next;

    logic                             div_valid;
    logic [atti_pkg::Q_WIDTH-1:0]     div_quot;
    atti_pkg::side_t                  div_side;

    logic                             idx_valid_reg;
    logic [atti_pkg::P_WIDTH-1:0]     idx_p_reg;
    atti_pkg::side_t                  idx_side_reg;

    logic [atti_pkg::IDX_WIDTH-1:0]   tab_lo;
    logic [atti_pkg::IDX_WIDTH-1:0]   tab_hi;
    logic [atti_pkg::TAB_WIDTH-1:0]   tab_a_next;
    logic [atti_pkg::TAB_WIDTH-1:0]   tab_step;
    logic [atti_pkg::DIFF_WIDTH-1:0]  tab_diff_next;

    logic                             tab_valid_reg;
    logic [atti_pkg::TAB_WIDTH-1:0]   tab_a_reg;
    logic [atti_pkg::DIFF_WIDTH-1:0]  tab_diff_reg;
    logic [atti_pkg::FRAC_BITS-1:0]   tab_frac_reg;
    atti_pkg::side_t                  tab_side_reg;

    logic                             mul_valid_reg;
    logic [atti_pkg::PROD_WIDTH-1:0]  mul_prod_reg;
    logic [atti_pkg::TAB_WIDTH-1:0]   mul_a_reg;
    atti_pkg::side_t                  mul_side_reg;

    logic [atti_pkg::PROD_WIDTH:0]    rnd_sum;
    logic [atti_pkg::ANGLE_WIDTH-1:0] r_interp;
    logic [atti_pkg::ANGLE_WIDTH-1:0] r_octant;
    logic [atti_pkg::ANGLE_WIDTH-1:0] angle_next;

    logic                             m_valid_reg;
    logic [atti_pkg::ANGLE_WIDTH-1:0] m_angle_turns_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Magnitudes; the most negative code maps to its exact magnitude.
    assign y_bits  = s_y_coord;
    assign x_bits  = s_x_coord;
    assign ay_next = y_bits[atti_pkg::COORD_WIDTH-1] ? (~y_bits + atti_pkg::MAG_ONE) : y_bits;
    assign ax_next = x_bits[atti_pkg::COORD_WIDTH-1] ? (~x_bits + atti_pkg::MAG_ONE) : x_bits;

    always_comb begin
        srt_side_next.y_neg = mag_yneg_reg;
        srt_side_next.x_neg = mag_xneg_reg;
        srt_side_next.y_big = mag_ay_reg >= mag_ax_reg;
        srt_side_next.zero  = (mag_ay_reg == '0) && (mag_ax_reg == '0);
    end

    atti_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (adv),
        .in_valid  (srt_valid_reg),
        .in_small  (srt_small_reg),
        .in_big    (srt_big_reg),
        .in_side   (srt_side_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    always_comb begin
        tab_lo     = idx_p_reg[atti_pkg::FRAC_BITS +: atti_pkg::IDX_WIDTH];
        tab_hi     = tab_lo + atti_pkg::IDX_ONE;
        tab_a_next = atti_pkg::ATAN_TABLE[tab_lo];
        tab_step   = atti_pkg::ATAN_TABLE[tab_hi] - tab_a_next;
        if (tab_lo == atti_pkg::LAST_IDX) begin
            tab_diff_next = '0;
        end else begin
            tab_diff_next = tab_step[atti_pkg::DIFF_WIDTH-1:0];
        end
    end

    always_comb begin
        rnd_sum  = {1'b0, mul_prod_reg} + atti_pkg::ROUND_HALF;
        r_interp = {{(atti_pkg::ANGLE_WIDTH-atti_pkg::TAB_WIDTH){1'b0}}, mul_a_reg}
                 + {{(atti_pkg::ANGLE_WIDTH-atti_pkg::DIFF_WIDTH-1){1'b0}},
                    rnd_sum[atti_pkg::PROD_WIDTH:atti_pkg::FRAC_BITS]};
        r_octant = mul_side_reg.y_big ? (atti_pkg::QUARTER_TURN - r_interp) : r_interp;
        case ({mul_side_reg.x_neg, mul_side_reg.y_neg})
            QUAD_FIRST:  angle_next = r_octant;
            QUAD_SECOND: angle_next = atti_pkg::HALF_TURN - r_octant;
            QUAD_THIRD:  angle_next = atti_pkg::HALF_TURN + r_octant;
            QUAD_FOURTH: angle_next = '0 - r_octant;
            default:     angle_next = r_octant;
        endcase
        if (mul_side_reg.zero) begin
            angle_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_valid_reg <= 1'b0;
            srt_valid_reg <= 1'b0;
            idx_valid_reg <= 1'b0;
            tab_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else if (adv) begin
            mag_valid_reg <= s_valid;
            srt_valid_reg <= mag_valid_reg;
            idx_valid_reg <= div_valid;
            tab_valid_reg <= idx_valid_reg;
            mul_valid_reg <= tab_valid_reg;
            m_valid_reg   <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag_ay_reg        <= ay_next;
            mag_ax_reg        <= ax_next;
            mag_yneg_reg      <= y_bits[atti_pkg::COORD_WIDTH-1];
            mag_xneg_reg      <= x_bits[atti_pkg::COORD_WIDTH-1];

            srt_small_reg     <= srt_side_next.y_big ? mag_ax_reg : mag_ay_reg;
            srt_big_reg       <= srt_side_next.y_big ? mag_ay_reg : mag_ax_reg;
            srt_side_reg      <= srt_side_next;

            idx_p_reg         <= {{atti_pkg::IDX_WIDTH{1'b0}}, div_quot}
                                 * atti_pkg::INTERVALS_P;
            idx_side_reg      <= div_side;

            tab_a_reg         <= tab_a_next;
            tab_diff_reg      <= tab_diff_next;
            tab_frac_reg      <= idx_p_reg[atti_pkg::FRAC_BITS-1:0];
            tab_side_reg      <= idx_side_reg;

            mul_prod_reg      <= {{atti_pkg::DIFF_WIDTH{1'b0}}, tab_frac_reg}
                                 * {{atti_pkg::FRAC_BITS{1'b0}}, tab_diff_reg};
            mul_a_reg         <= tab_a_reg;
            mul_side_reg      <= tab_side_reg;

            m_angle_turns_reg <= angle_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_angle_turns = m_angle_turns_reg;

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_valid_reg && !idx_side_reg.zero |-> idx_p_reg <= atti_pkg::MAX_P)
        else $error("table position beyond last point");

    a_first_octant: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_valid_reg && !mul_side_reg.zero |-> r_interp <= atti_pkg::EIGHTH_TURN)
        else $error("interpolated angle outside first octant");

    a_mul_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv && mul_valid_reg |=> mul_valid_reg && $stable(mul_prod_reg))
        else $error("multiply stage changed while stalled");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the table-interpolated atan2 core, with its own angle predictor.
`timescale 1ns / 1ps

module testbench;

    localparam longint unsigned ONE_Q30           = 64'd1 << 30;
    localparam longint unsigned TURNS_PER_RAD_Q32 = 64'd683565275;
    localparam int              RX_ALWAYS         = 0;
    localparam int              RX_RANDOM         = 1;
    localparam int              RX_PERIODIC       = 2;

    logic                                    aclk          = 1'b0;
    logic                                    aresetn       = 1'b0;
    logic                                    s_valid       = 1'b0;
    logic                                    s_ready;
    logic signed [atti_pkg::COORD_WIDTH-1:0] s_y_coord     = '0;
    logic signed [atti_pkg::COORD_WIDTH-1:0] s_x_coord     = '0;
    logic                                    m_valid;
    logic                                    m_ready       = 1'b0;
    logic [atti_pkg::ANGLE_WIDTH-1:0]        m_angle_turns;

    logic [atti_pkg::ANGLE_WIDTH-1:0] angle_expected [$];
    int                               mismatch_count = 0;
    int                               burst_left     = 0;
    bit                               sender_bursty  = 1'b1;
    int                               rx_mode        = RX_ALWAYS;
    int                               rx_phase       = 0;
    int                               hold_request   = 0;
    int                               hold_left      = 0;

    atan2_turns_table_interp_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_y_coord     (s_y_coord),
        .s_x_coord     (s_x_coord),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_angle_turns (m_angle_turns)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint unsigned tan_half(longint unsigned t);
        longint unsigned t2;
        longint unsigned v;
        longint unsigned root;
        longint unsigned probe;
        t2 = (t * t) >> 30;
        v = (ONE_Q30 + t2) << 30;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return (t << 30) / (ONE_Q30 + root);
    endfunction

    function automatic int atan_point(int k);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned term;
        longint unsigned pos_sum;
        longint unsigned neg_sum;
        longint unsigned ang;
        longint unsigned divisor;
        t = (longint'(k) << 30) / atti_pkg::TABLE_INTERVALS;
        t = tan_half(tan_half(t));
        t2 = (t * t) >> 30;
        term = t;
        pos_sum = t;
        neg_sum = 0;
        for (int n = 1; n <= 12; n++) begin
            term = (term * t2) >> 30;
            divisor = 64'(2 * n + 1);
            if (n % 2 == 1) begin
                neg_sum = neg_sum + term / divisor;
            end else begin
                pos_sum = pos_sum + term / divisor;
            end
        end
        ang = (pos_sum >= neg_sum) ? 4 * (pos_sum - neg_sum) : 0;
        return int'((ang * TURNS_PER_RAD_Q32 + (64'd1 << 45)) >> 46);
    endfunction

    function automatic logic [atti_pkg::ANGLE_WIDTH-1:0] predict_angle(
        logic signed [atti_pkg::COORD_WIDTH-1:0] y,
        logic signed [atti_pkg::COORD_WIDTH-1:0] x
    );
        int   ay;
        int   ax;
        int   small_mag;
        int   big_mag;
        int   ratio;
        int   pos;
        int   lo;
        int   frac;
        int   pa;
        int   pb;
        int   r;
        logic y_neg;
        logic x_neg;
        logic y_big;
        y_neg = y[atti_pkg::COORD_WIDTH-1];
        x_neg = x[atti_pkg::COORD_WIDTH-1];
        ay = y_neg ? -int'(y) : int'(y);
        ax = x_neg ? -int'(x) : int'(x);
        if (ax == 0 && ay == 0)
            return '0;
        y_big = (ay >= ax);
        small_mag = y_big ? ax : ay;
        big_mag = y_big ? ay : ax;
        ratio = int'((longint'(small_mag) << atti_pkg::FRAC_BITS) / longint'(big_mag));
        pos = ratio * atti_pkg::TABLE_INTERVALS;
        lo = pos >> atti_pkg::FRAC_BITS;
        frac = pos & 16'hFFFF;
        if (lo >= atti_pkg::TABLE_INTERVALS) begin
            r = atan_point(atti_pkg::TABLE_INTERVALS);
        end else begin
            pa = atan_point(lo);
            pb = atan_point(lo + 1);
            r = pa + ((frac * (pb - pa) + 32'h8000) >> atti_pkg::FRAC_BITS);
        end
        if (y_big)
            r = 16384 - r;
        if (x_neg && !y_neg)
            r = 32768 - r;
        else if (x_neg && y_neg)
            r = 32768 + r;
        else if (!x_neg && y_neg)
            r = 65536 - r;
        return atti_pkg::ANGLE_WIDTH'(r);
    endfunction

    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        rx_phase = (rx_phase + 1) % 7;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_RANDOM: begin
                    m_ready <= ($urandom_range(0, 9) >= 3);
                end
                RX_PERIODIC: begin
                    m_ready <= (rx_phase < 4);
                end
                default: begin
                    m_ready <= 1'b1;
                end
            endcase
        end
    end

    always @(posedge aclk) begin : check_angles
        logic [atti_pkg::ANGLE_WIDTH-1:0] want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (angle_expected.size() == 0) begin
                    $error("m_angle_turns: expected none, actual %0d", m_angle_turns);
                    mismatch_count++;
                end else begin
                    want = angle_expected.pop_front();
                    if (m_angle_turns !== want) begin
                        $error("m_angle_turns: expected %0d, actual %0d", want, m_angle_turns);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                angle_expected.push_back(predict_angle(s_y_coord, s_x_coord));
        end
    end

    task automatic send_coords(logic signed [atti_pkg::COORD_WIDTH-1:0] y,
                               logic signed [atti_pkg::COORD_WIDTH-1:0] x);
        int gap;
        if (sender_bursty && burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_y_coord <= y;
        s_x_coord <= x;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (angle_expected.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic test_axes_and_extremes();
        logic signed [atti_pkg::COORD_WIDTH-1:0] ys [] = '{
            0, 0, 32767, 0, -32768, 32767, 32767, -32767, -32767, -32768,
            -32768, 32767, -1, -1, 1, 1, 32767, -32768, 1, 0,
            -1, 100, -32768, 5
        };
        logic signed [atti_pkg::COORD_WIDTH-1:0] xs [] = '{
            0, 32767, 0, -32768, 0, 32767, -32767, -32767, 32767, -32768,
            32767, -32768, 32767, -32768, -32768, 32767, 1, -1, 0, -1,
            0, 1500, -32767, 5
        };
        rx_mode = RX_ALWAYS;
        sender_bursty = 1'b0;
        foreach (ys[i])
            send_coords(ys[i], xs[i]);
        sender_bursty = 1'b1;
    endtask

    task automatic test_uniform_vectors();
        rx_mode = RX_RANDOM;
        repeat (150)
            send_coords(atti_pkg::COORD_WIDTH'($urandom), atti_pkg::COORD_WIDTH'($urandom));
    endtask

    task automatic test_short_vectors();
        int ry;
        int rx;
        rx_mode = RX_PERIODIC;
        repeat (100) begin
            ry = $urandom_range(0, 16);
            rx = $urandom_range(0, 16);
            send_coords(atti_pkg::COORD_WIDTH'(ry - 8), atti_pkg::COORD_WIDTH'(rx - 8));
        end
    endtask

    task automatic test_scaled_vectors();
        logic signed [atti_pkg::COORD_WIDTH-1:0] ry;
        logic signed [atti_pkg::COORD_WIDTH-1:0] rx;
        rx_mode = RX_RANDOM;
        repeat (130) begin
            ry = atti_pkg::COORD_WIDTH'($urandom);
            rx = atti_pkg::COORD_WIDTH'($urandom);
            ry = ry >>> $urandom_range(0, 15);
            rx = rx >>> $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0)
                rx = atti_pkg::COORD_WIDTH'(int'(ry) + int'($urandom_range(0, 4)) - 2);
            send_coords(ry, rx);
        end
    endtask

    task automatic test_output_backpressure();
        rx_mode = RX_ALWAYS;
        sender_bursty = 1'b0;
        hold_request = 150;
        repeat (50)
            send_coords(atti_pkg::COORD_WIDTH'($urandom), atti_pkg::COORD_WIDTH'($urandom));
        sender_bursty = 1'b1;
        drain_results();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_axes_and_extremes();
        test_output_backpressure();
        test_uniform_vectors();
        test_short_vectors();
        test_scaled_vectors();
        drain_results();
        if (mismatch_count == 0 && angle_expected.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
